@@ rtl/core/sliding_mode_velocity_controller_defines.svh @@
// Shared assertion macros for the controller core.
`ifndef SLIDING_MODE_VELOCITY_CONTROLLER_DEFINES_SVH
`define SLIDING_MODE_VELOCITY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMVC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/smvc_pkg.sv @@
package smvc_pkg;

  localparam int VEHICLES_DEF = 64;
  localparam int WINDOW_DEF   = 10;
  localparam int CORDIC_STEPS = 24;
  localparam int PI_Q         = 205887;
  localparam int HALF_PI_Q    = 102944;
  localparam int CORDIC_K     = 652032874;
  localparam int UNIT_Q       = 65536;
  localparam int ROT_LIMIT    = 92682;
  localparam int IDX_W        = 11;   // sequencer index, covers up to 2048 vehicles
  localparam int CNT_W        = 6;    // window fill count, covers up to 63

  // config register indexes
  localparam logic [2:0] REG_SLOPE        = 3'd0;
  localparam logic [2:0] REG_GAIN         = 3'd1;
  localparam logic [2:0] REG_DERIV        = 3'd2;
  localparam logic [2:0] REG_GOAL_X       = 3'd3;
  localparam logic [2:0] REG_GOAL_Y       = 3'd4;
  localparam logic [2:0] REG_GOAL_Z       = 3'd5;
  localparam logic [2:0] REG_GOAL_HEADING = 3'd6;

  // datapath operations
  localparam logic [4:0] OP_NOP         = 5'd0;
  localparam logic [4:0] OP_CLEAR       = 5'd1;
  localparam logic [4:0] OP_LOAD        = 5'd2;
  localparam logic [4:0] OP_MUL_SX      = 5'd3;
  localparam logic [4:0] OP_SET_SX      = 5'd4;
  localparam logic [4:0] OP_MUL_SY      = 5'd5;
  localparam logic [4:0] OP_SET_SY      = 5'd6;
  localparam logic [4:0] OP_MUL_SZ      = 5'd7;
  localparam logic [4:0] OP_SET_SZ      = 5'd8;
  localparam logic [4:0] OP_WRITE       = 5'd9;
  localparam logic [4:0] OP_SUM         = 5'd10;
  localparam logic [4:0] OP_DIV_START   = 5'd11;
  localparam logic [4:0] OP_DIV_STEP    = 5'd12;
  localparam logic [4:0] OP_MUL_GX      = 5'd13;
  localparam logic [4:0] OP_MUL_KX      = 5'd14;
  localparam logic [4:0] OP_SET_CX      = 5'd15;
  localparam logic [4:0] OP_MUL_GY      = 5'd16;
  localparam logic [4:0] OP_MUL_KY      = 5'd17;
  localparam logic [4:0] OP_SET_CY      = 5'd18;
  localparam logic [4:0] OP_MUL_GZ      = 5'd19;
  localparam logic [4:0] OP_SET_CZ      = 5'd20;
  localparam logic [4:0] OP_CORDIC_INIT = 5'd21;
  localparam logic [4:0] OP_CORDIC_STEP = 5'd22;
  localparam logic [4:0] OP_MUL_RX      = 5'd23;
  localparam logic [4:0] OP_MUL_RY      = 5'd24;
  localparam logic [4:0] OP_SET_RY      = 5'd25;
  localparam logic [4:0] OP_OUT         = 5'd26;

  typedef struct packed {
    logic [4:0]       op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic             go;
    logic             rotate;
    logic             out_busy;
    logic [CNT_W-1:0] cnt;
  } status_t;

  typedef struct packed {
    logic        [23:0] slider_slope;
    logic        [23:0] slider_gain;
    logic        [23:0] deriv_gain_rate;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [18:0] goal_heading;
  } cfg_t;

  // arctan(2^-i) in Q2.30
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/smvc_ctrl.sv @@
`include "sliding_mode_velocity_controller_defines.svh"

module smvc_ctrl #(
  parameter int VEHICLES = smvc_pkg::VEHICLES_DEF,
  parameter int WINDOW   = smvc_pkg::WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output smvc_pkg::cmd_t   cmd,
  input  smvc_pkg::status_t status
);

  localparam int SUMW = 32 + $clog2(WINDOW);
  localparam int IW   = smvc_pkg::IDX_W;

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_READ  = 5'd2;
  localparam logic [4:0] ST_MSX   = 5'd3;
  localparam logic [4:0] ST_SSX   = 5'd4;
  localparam logic [4:0] ST_MSY   = 5'd5;
  localparam logic [4:0] ST_SSY   = 5'd6;
  localparam logic [4:0] ST_MSZ   = 5'd7;
  localparam logic [4:0] ST_SSZ   = 5'd8;
  localparam logic [4:0] ST_WR    = 5'd9;
  localparam logic [4:0] ST_SUM   = 5'd10;
  localparam logic [4:0] ST_DIV0  = 5'd11;
  localparam logic [4:0] ST_DIV   = 5'd12;
  localparam logic [4:0] ST_MGX   = 5'd13;
  localparam logic [4:0] ST_MKX   = 5'd14;
  localparam logic [4:0] ST_SCX   = 5'd15;
  localparam logic [4:0] ST_MGY   = 5'd16;
  localparam logic [4:0] ST_MKY   = 5'd17;
  localparam logic [4:0] ST_SCY   = 5'd18;
  localparam logic [4:0] ST_MGZ   = 5'd19;
  localparam logic [4:0] ST_SCZ   = 5'd20;
  localparam logic [4:0] ST_CINIT = 5'd21;
  localparam logic [4:0] ST_CSTEP = 5'd22;
  localparam logic [4:0] ST_MRX   = 5'd23;
  localparam logic [4:0] ST_MRY   = 5'd24;
  localparam logic [4:0] ST_SRY   = 5'd25;
  localparam logic [4:0] ST_OUT   = 5'd26;

  logic [4:0]    state, state_next;
  logic [IW-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = smvc_pkg::OP_NOP;
    cmd.idx    = idx;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = smvc_pkg::OP_CLEAR;
        if (idx == IW'(VEHICLES - 1)) begin
          state_next = ST_IDLE;
          idx_next   = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = smvc_pkg::OP_LOAD;
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = status.go ? ST_MSX : ST_IDLE;
      ST_MSX: begin
        cmd.op = smvc_pkg::OP_MUL_SX;
        state_next = ST_SSX;
      end
      ST_SSX: begin
        cmd.op = smvc_pkg::OP_SET_SX;
        state_next = ST_MSY;
      end
      ST_MSY: begin
        cmd.op = smvc_pkg::OP_MUL_SY;
        state_next = ST_SSY;
      end
      ST_SSY: begin
        cmd.op = smvc_pkg::OP_SET_SY;
        state_next = ST_MSZ;
      end
      ST_MSZ: begin
        cmd.op = smvc_pkg::OP_MUL_SZ;
        state_next = ST_SSZ;
      end
      ST_SSZ: begin
        cmd.op = smvc_pkg::OP_SET_SZ;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op     = smvc_pkg::OP_WRITE;
        idx_next   = '0;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = smvc_pkg::OP_SUM;
        if (idx == IW'(status.cnt)) begin
          idx_next   = '0;
          state_next = ST_DIV0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DIV0: begin
        cmd.op = smvc_pkg::OP_DIV_START;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = smvc_pkg::OP_DIV_STEP;
        if (idx == IW'(SUMW - 1)) begin
          idx_next   = '0;
          state_next = ST_MGX;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_MGX: begin
        cmd.op = smvc_pkg::OP_MUL_GX;
        state_next = ST_MKX;
      end
      ST_MKX: begin
        cmd.op = smvc_pkg::OP_MUL_KX;
        state_next = ST_SCX;
      end
      ST_SCX: begin
        cmd.op = smvc_pkg::OP_SET_CX;
        state_next = ST_MGY;
      end
      ST_MGY: begin
        cmd.op = smvc_pkg::OP_MUL_GY;
        state_next = ST_MKY;
      end
      ST_MKY: begin
        cmd.op = smvc_pkg::OP_MUL_KY;
        state_next = ST_SCY;
      end
      ST_SCY: begin
        cmd.op = smvc_pkg::OP_SET_CY;
        state_next = ST_MGZ;
      end
      ST_MGZ: begin
        cmd.op = smvc_pkg::OP_MUL_GZ;
        state_next = ST_SCZ;
      end
      ST_SCZ: begin
        cmd.op = smvc_pkg::OP_SET_CZ;
        state_next = status.rotate ? ST_CINIT : ST_OUT;
      end
      ST_CINIT: begin
        cmd.op     = smvc_pkg::OP_CORDIC_INIT;
        idx_next   = '0;
        state_next = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.op = smvc_pkg::OP_CORDIC_STEP;
        if (idx == IW'(smvc_pkg::CORDIC_STEPS - 1)) begin
          idx_next   = '0;
          state_next = ST_MRX;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_MRX: begin
        cmd.op = smvc_pkg::OP_MUL_RX;
        state_next = ST_MRY;
      end
      ST_MRY: begin
        cmd.op = smvc_pkg::OP_MUL_RY;
        state_next = ST_SRY;
      end
      ST_SRY: begin
        cmd.op = smvc_pkg::OP_SET_RY;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.op     = smvc_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        idx_next   = '0;
      end
    endcase
  end

  `SMVC_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state == ST_READ, "accept did not start a read")
  `SMVC_ASSERT_SAME(a_sum_bound, state == ST_SUM, idx <= IW'(status.cnt), "window sum ran past fill count")
  `SMVC_ASSERT_SAME(a_cordic_bound, state == ST_CSTEP, idx < IW'(smvc_pkg::CORDIC_STEPS), "rotation ran too long")

endmodule

@@ rtl/core/smvc_dp.sv @@
module smvc_dp #(
  parameter int VEHICLES = smvc_pkg::VEHICLES_DEF,
  parameter int WINDOW   = smvc_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  smvc_pkg::cmd_t     cmd,
  output smvc_pkg::status_t  status,
  input  smvc_pkg::cfg_t     cfg,
  input  logic [5:0]         vehicle,
  input  logic signed [31:0] est_x,
  input  logic signed [31:0] est_y,
  input  logic signed [31:0] est_z,
  input  logic signed [31:0] est_vx,
  input  logic signed [31:0] est_vy,
  input  logic signed [31:0] est_vz,
  input  logic signed [18:0] est_heading,
  input  logic signed [31:0] path_vx,
  input  logic signed [31:0] path_vy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_vehicle,
  output logic signed [17:0] cmd_vx,
  output logic signed [17:0] cmd_vy,
  output logic signed [17:0] cmd_vz,
  output logic signed [18:0] cmd_yaw_rate
);

  localparam int VIDW  = (VEHICLES > 1) ? $clog2(VEHICLES) : 1;
  localparam int SLOTW = $clog2(WINDOW);
  localparam int WAW   = $clog2(VEHICLES * WINDOW);
  localparam int SUMW  = 32 + $clog2(WINDOW);
  localparam int CW    = smvc_pkg::CNT_W;

  typedef struct packed {
    logic               active;
    logic               full;
    logic [SLOTW-1:0]   slot;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
  } vstate_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    else if (v < -68'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [67:0] rnd16(input logic signed [67:0] v);
    return (v + 68'sd32768) >>> 16;
  endfunction

  function automatic logic signed [67:0] rnd44(input logic signed [67:0] v);
    return (v + (68'sd1 <<< 43)) >>> 44;
  endfunction

  function automatic logic signed [17:0] clamp18(input logic signed [67:0] v,
                                                 input logic signed [67:0] lim);
    if (v > lim) return 18'(lim);
    else if (v < -lim) return 18'(-lim);
    else return v[17:0];
  endfunction

  // latched item
  logic [5:0]         v_r;
  logic [VIDW-1:0]    vaddr;
  logic               ok_r;
  logic signed [31:0] ex, ey, ez, evx, evy, evz, pvx, pvy;
  logic signed [18:0] eh;

  // per-vehicle state memory
  vstate_t         smem [VEHICLES];
  vstate_t         srd, sm_wdata;
  logic            sm_we;
  logic [VIDW-1:0] sm_waddr;

  // surface change windows
  logic signed [31:0] wxm [VEHICLES * WINDOW];
  logic signed [31:0] wym [VEHICLES * WINDOW];
  logic signed [31:0] wxrd, wyrd, win_dx, win_dy;
  logic               win_we, win_re;
  logic [WAW-1:0]     win_base, win_waddr, win_raddr;

  // arithmetic registers
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] prod, p, acc;
  logic signed [31:0] sx, sy, sz;
  logic [CW-1:0]      cnt;
  logic signed [SUMW-1:0] sumx, sumy;
  logic [SUMW-1:0]    qx, qy;
  logic [CW-1:0]      remx, remy;
  logic               negx, negy;
  logic [CW:0]        shx, shy;
  logic signed [31:0] avgx, avgy;
  logic signed [17:0] cx, cy, cz;
  logic signed [18:0] yaw;
  logic signed [35:0] cox, coy, dxs, dys;
  logic signed [33:0] coz;
  logic signed [19:0] hdiff, th;
  logic [SLOTW-1:0]   slot_cur;
  logic               wrap;
  logic signed [31:0] slope_s, gain_s, kdt_s;
  logic signed [32:0] dgx, dgy, dgz;

  assign slope_s = $signed({8'b0, cfg.slider_slope});
  assign gain_s  = $signed({8'b0, cfg.slider_gain});
  assign kdt_s   = $signed({8'b0, cfg.deriv_gain_rate});
  assign dgx = 33'(cfg.goal_x) - 33'(ex);
  assign dgy = 33'(cfg.goal_y) - 33'(ey);
  assign dgz = 33'(cfg.goal_z) - 33'(ez);

  assign avgx = negx ? 32'(-qx) : 32'(qx);
  assign avgy = negy ? 32'(-qy) : 32'(qy);

  assign slot_cur = (int'(srd.slot) >= WINDOW) ? '0 : srd.slot;
  assign wrap     = (int'(slot_cur) == WINDOW - 1);
  assign win_base = WAW'(vaddr) * WAW'(WINDOW);

  assign shx = {remx, qx[SUMW-1]};
  assign shy = {remy, qy[SUMW-1]};

  assign dxs = cox >>> cmd.idx[4:0];
  assign dys = coy >>> cmd.idx[4:0];

  // heading fold into (-pi/2, pi/2]; one correction covers the input range
  always_comb begin
    th = 20'(eh);
    if (20'(eh) > 20'sd102944) th = 20'(eh) - 20'(smvc_pkg::PI_Q);
    else if (20'(eh) <= -20'sd102944) th = 20'(eh) + 20'(smvc_pkg::PI_Q);
  end
  assign hdiff = 20'(cfg.goal_heading) - 20'(eh);

  assign status.go       = ok_r && (srd.active || ex != 32'sd0 || ey != 32'sd0);
  assign status.rotate   = (cx != 18'sd0) && (cy != 18'sd0);
  assign status.out_busy = out_valid && !out_ready;
  assign status.cnt      = cnt;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      smvc_pkg::OP_MUL_SX: begin mul_a = 36'(dgx); mul_b = slope_s; end
      smvc_pkg::OP_MUL_SY: begin mul_a = 36'(dgy); mul_b = slope_s; end
      smvc_pkg::OP_MUL_SZ: begin mul_a = 36'(dgz); mul_b = slope_s; end
      smvc_pkg::OP_MUL_GX: begin mul_a = 36'(sx);  mul_b = gain_s;  end
      smvc_pkg::OP_MUL_GY: begin mul_a = 36'(sy);  mul_b = gain_s;  end
      smvc_pkg::OP_MUL_GZ: begin mul_a = 36'(sz);  mul_b = gain_s;  end
      smvc_pkg::OP_MUL_KX: begin mul_a = 36'(avgx); mul_b = kdt_s;  end
      smvc_pkg::OP_MUL_KY: begin mul_a = 36'(avgy); mul_b = kdt_s;  end
      smvc_pkg::OP_MUL_RX: begin mul_a = cox; mul_b = 32'(smvc_pkg::CORDIC_K); end
      smvc_pkg::OP_MUL_RY: begin mul_a = coy; mul_b = 32'(smvc_pkg::CORDIC_K); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // memory port controls
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = vaddr;
    sm_wdata = '0;
    win_we   = 1'b0;
    win_re   = 1'b0;
    win_waddr = win_base + WAW'(slot_cur);
    win_raddr = win_base + WAW'(cmd.idx);
    win_dx   = sat32(68'(sx) - 68'(srd.prev_x));
    win_dy   = sat32(68'(sy) - 68'(srd.prev_y));
    case (cmd.op)
      smvc_pkg::OP_CLEAR: begin
        sm_we    = 1'b1;
        sm_waddr = VIDW'(cmd.idx);
      end
      smvc_pkg::OP_WRITE: begin
        sm_we           = 1'b1;
        win_we          = 1'b1;
        sm_wdata.active = 1'b1;
        sm_wdata.full   = srd.full | wrap;
        sm_wdata.slot   = wrap ? '0 : slot_cur + 1'b1;
        sm_wdata.prev_x = sx;
        sm_wdata.prev_y = sy;
      end
      smvc_pkg::OP_SUM: win_re = (cmd.idx < smvc_pkg::IDX_W'(cnt));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_waddr] <= sm_wdata;
    if (cmd.op == smvc_pkg::OP_LOAD) srd <= smem[VIDW'(vehicle)];
  end

  always_ff @(posedge clk) begin
    if (win_we) wxm[win_waddr] <= win_dx;
    if (win_re) wxrd <= wxm[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) wym[win_waddr] <= win_dy;
    if (win_re) wyrd <= wym[win_raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      smvc_pkg::OP_LOAD: begin
        v_r   <= vehicle;
        vaddr <= VIDW'(vehicle);
        ok_r  <= (int'(vehicle) < VEHICLES);
        ex <= est_x;  ey <= est_y;  ez <= est_z;
        evx <= est_vx; evy <= est_vy; evz <= est_vz;
        eh <= est_heading;
        pvx <= path_vx; pvy <= path_vy;
      end
      smvc_pkg::OP_MUL_SX, smvc_pkg::OP_MUL_SY, smvc_pkg::OP_MUL_SZ,
      smvc_pkg::OP_MUL_GX, smvc_pkg::OP_MUL_GY, smvc_pkg::OP_MUL_GZ,
      smvc_pkg::OP_MUL_RX:
        p <= prod;
      smvc_pkg::OP_SET_SX: sx <= sat32(68'(evx) - rnd16(p));
      smvc_pkg::OP_SET_SY: sy <= sat32(68'(evy) - rnd16(p));
      smvc_pkg::OP_SET_SZ: sz <= sat32(68'(evz) - rnd16(p));
      smvc_pkg::OP_WRITE: begin
        cnt  <= srd.full ? CW'(WINDOW) : CW'(slot_cur) + 1'b1;
        sumx <= '0;
        sumy <= '0;
      end
      smvc_pkg::OP_SUM: begin
        if (cmd.idx != '0) begin
          sumx <= sumx + SUMW'(wxrd);
          sumy <= sumy + SUMW'(wyrd);
        end
      end
      smvc_pkg::OP_DIV_START: begin
        negx <= sumx[SUMW-1];
        negy <= sumy[SUMW-1];
        qx   <= sumx[SUMW-1] ? SUMW'(-sumx) : SUMW'(sumx);
        qy   <= sumy[SUMW-1] ? SUMW'(-sumy) : SUMW'(sumy);
        remx <= '0;
        remy <= '0;
      end
      smvc_pkg::OP_DIV_STEP: begin
        if (shx >= (CW + 1)'(cnt)) begin
          remx <= CW'(shx - (CW + 1)'(cnt));
          qx   <= {qx[SUMW-2:0], 1'b1};
        end else begin
          remx <= shx[CW-1:0];
          qx   <= {qx[SUMW-2:0], 1'b0};
        end
        if (shy >= (CW + 1)'(cnt)) begin
          remy <= CW'(shy - (CW + 1)'(cnt));
          qy   <= {qy[SUMW-2:0], 1'b1};
        end else begin
          remy <= shy[CW-1:0];
          qy   <= {qy[SUMW-2:0], 1'b0};
        end
      end
      smvc_pkg::OP_MUL_KX: begin
        acc <= -p;
        p   <= prod;
      end
      smvc_pkg::OP_SET_CX:
        cx <= clamp18(rnd16(acc + p + (68'(pvx) <<< 16)), 68'(smvc_pkg::UNIT_Q));
      smvc_pkg::OP_MUL_KY: begin
        acc <= p;
        p   <= prod;
      end
      smvc_pkg::OP_SET_CY:
        cy <= clamp18(rnd16(acc + p + (68'(pvy) <<< 16)), 68'(smvc_pkg::UNIT_Q));
      smvc_pkg::OP_SET_CZ: begin
        cz  <= clamp18(rnd16(-p), 68'(smvc_pkg::UNIT_Q));
        yaw <= 19'((hdiff + (hdiff[19] ? 20'sd1 : 20'sd0)) >>> 1);
      end
      smvc_pkg::OP_CORDIC_INIT: begin
        cox <= 36'(cx) <<< 14;
        coy <= 36'(cy) <<< 14;
        coz <= -(34'(th) <<< 14);
      end
      smvc_pkg::OP_CORDIC_STEP: begin
        if (!coz[33]) begin
          cox <= cox - dys;
          coy <= coy + dxs;
          coz <= coz - 34'(smvc_pkg::atan_at(cmd.idx[4:0]));
        end else begin
          cox <= cox + dys;
          coy <= coy - dxs;
          coz <= coz + 34'(smvc_pkg::atan_at(cmd.idx[4:0]));
        end
      end
      smvc_pkg::OP_MUL_RY: begin
        cx <= clamp18(rnd44(p), 68'(smvc_pkg::ROT_LIMIT));
        p  <= prod;
      end
      smvc_pkg::OP_SET_RY: cy <= clamp18(rnd44(p), 68'(smvc_pkg::ROT_LIMIT));
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == smvc_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == smvc_pkg::OP_OUT) begin
      out_vehicle  <= v_r;
      cmd_vx       <= cx;
      cmd_vy       <= cy;
      cmd_vz       <= cz;
      cmd_yaw_rate <= yaw;
    end
  end

endmodule

@@ rtl/core/sliding_mode_velocity_controller.sv @@
// One item at a time: each walks the serial window sum, the 32 + ceil(log2(WINDOW))
//   step divider and, with rotation, the 24-step CORDIC before the next is taken.
// Reset: synchronous; afterward a clearing pass over all VEHICLES entries wipes the
//   per-vehicle state memory while in_ready stays low; config writes are taken.
module sliding_mode_velocity_controller #(
  parameter int VEHICLES = smvc_pkg::VEHICLES_DEF,
  parameter int WINDOW   = smvc_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // estimate channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         vehicle,
  input  logic signed [31:0] est_x,
  input  logic signed [31:0] est_y,
  input  logic signed [31:0] est_z,
  input  logic signed [31:0] est_vx,
  input  logic signed [31:0] est_vy,
  input  logic signed [31:0] est_vz,
  input  logic signed [18:0] est_heading,
  input  logic signed [31:0] path_vx,
  input  logic signed [31:0] path_vy,
  // command channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_vehicle,
  output logic signed [17:0] cmd_vx,
  output logic signed [17:0] cmd_vy,
  output logic signed [17:0] cmd_vz,
  output logic signed [18:0] cmd_yaw_rate
);

  smvc_pkg::cfg_t    cfg;
  smvc_pkg::cmd_t    cmd;
  smvc_pkg::status_t status;

  // Config registers. Writes are only expected while the core is idle, so
  // the port always takes a transfer; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slider_slope    <= 24'd52429;   // 0.8
      cfg.slider_gain     <= 24'd52429;   // 0.8
      cfg.deriv_gain_rate <= 24'd0;
      cfg.goal_x          <= '0;
      cfg.goal_y          <= '0;
      cfg.goal_z          <= '0;
      cfg.goal_heading    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        smvc_pkg::REG_SLOPE:        cfg.slider_slope    <= cfg_data[23:0];
        smvc_pkg::REG_GAIN:         cfg.slider_gain     <= cfg_data[23:0];
        smvc_pkg::REG_DERIV:        cfg.deriv_gain_rate <= cfg_data[23:0];
        smvc_pkg::REG_GOAL_X:       cfg.goal_x          <= $signed(cfg_data);
        smvc_pkg::REG_GOAL_Y:       cfg.goal_y          <= $signed(cfg_data);
        smvc_pkg::REG_GOAL_Z:       cfg.goal_z          <= $signed(cfg_data);
        smvc_pkg::REG_GOAL_HEADING: cfg.goal_heading    <= $signed(cfg_data[18:0]);
        default: ;
      endcase
    end
  end

  // Sequencer: walks one estimate through surfaces, window update, average
  // divide, output terms and the optional rotation.
  smvc_ctrl #(
    .VEHICLES(VEHICLES),
    .WINDOW  (WINDOW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .status  (status)
  );

  // Datapath: shared multiplier, state and window memories, divider lanes,
  // CORDIC registers and the result register that holds a finished command
  // until its transfer completes.
  smvc_dp #(
    .VEHICLES(VEHICLES),
    .WINDOW  (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .vehicle     (vehicle),
    .est_x       (est_x),
    .est_y       (est_y),
    .est_z       (est_z),
    .est_vx      (est_vx),
    .est_vy      (est_vy),
    .est_vz      (est_vz),
    .est_heading (est_heading),
    .path_vx     (path_vx),
    .path_vy     (path_vy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_vehicle (out_vehicle),
    .cmd_vx      (cmd_vx),
    .cmd_vy      (cmd_vy),
    .cmd_vz      (cmd_vz),
    .cmd_yaw_rate(cmd_yaw_rate)
  );

endmodule

@@ bench/sliding_mode_velocity_controller_tb.sv @@
module sliding_mode_velocity_controller_tb;

  // index past the register list, must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DOG_LIMIT  = 4000;   // idle cycles before we call it hung
  localparam int SETTLE     = 150;    // > worst latency with rotation
  localparam int LONG_HOLD  = 400;

  // atan(2^-i), Q2.30
  localparam longint ATAN_Q30 [smvc_pkg::CORDIC_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  typedef struct {
    logic [5:0]         veh;
    logic signed [31:0] x, y, z, vx, vy, vz;
    logic signed [18:0] hdg;
    logic signed [31:0] pvx, pvy;
  } estimate_t;

  typedef struct {
    logic [5:0]         veh;
    logic signed [17:0] vx, vy, vz;
    logic signed [18:0] yaw;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [5:0] vehicle = '0;
  logic signed [31:0] est_x = '0, est_y = '0, est_z = '0;
  logic signed [31:0] est_vx = '0, est_vy = '0, est_vz = '0;
  logic signed [18:0] est_heading = '0;
  logic signed [31:0] path_vx = '0, path_vy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_vehicle;
  logic signed [17:0] cmd_vx, cmd_vy, cmd_vz;
  logic signed [18:0] cmd_yaw_rate;

  sliding_mode_velocity_controller DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller shadow: config registers and per-vehicle surface/window state
  // ---------------------------------------------------------------------------
  logic [23:0] m_slope = 24'd52429, m_gain = 24'd52429, m_kdt = '0;
  longint m_goal_x = 0, m_goal_y = 0, m_goal_z = 0, m_goal_hdg = 0;
  bit     m_active [64];
  longint m_prev_sx [64], m_prev_sy [64];
  longint m_win_dx [64][10], m_win_dy [64][10];
  int     m_slot [64];
  bit     m_full [64];

  estimate_t estimate_q[$];     // waiting to be offered
  command_t  predicted_cmds[$]; // commands the block owes us
  int  errors = 0;
  bit  calm = 1'b0;             // no idling on either side
  bit  hold_req = 1'b0;         // ask the receiver for one long hold-off

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // round half up from Q32 product scale to Q16.16
  function automatic longint half_up16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      smvc_pkg::REG_SLOPE:        m_slope = d[23:0];
      smvc_pkg::REG_GAIN:         m_gain = d[23:0];
      smvc_pkg::REG_DERIV:        m_kdt = d[23:0];
      smvc_pkg::REG_GOAL_X:       m_goal_x = longint'($signed(d));
      smvc_pkg::REG_GOAL_Y:       m_goal_y = longint'($signed(d));
      smvc_pkg::REG_GOAL_Z:       m_goal_z = longint'($signed(d));
      smvc_pkg::REG_GOAL_HEADING: m_goal_hdg = longint'($signed(d[18:0]));
      default: ;
    endcase
  endfunction

  // One control step for one vehicle; returns 0 when the vehicle stays silent.
  function automatic bit compute_command(input estimate_t e, output command_t c);
    longint slope, gain, kdt, sx, sy, sz, sumx, sumy, cnt, avgx, avgy;
    longint cx, cy, cz, yaw, th, rx, ry, rz, dx, dy;
    int v, s;
    v = e.veh;
    if (e.x != 0 || e.y != 0) m_active[v] = 1'b1;
    if (!m_active[v]) return 1'b0;
    slope = longint'(m_slope);
    gain  = longint'(m_gain);
    kdt   = longint'(m_kdt);
    sx = sat32(longint'(e.vx) - half_up16(slope * (m_goal_x - longint'(e.x))));
    sy = sat32(longint'(e.vy) - half_up16(slope * (m_goal_y - longint'(e.y))));
    sz = sat32(longint'(e.vz) - half_up16(slope * (m_goal_z - longint'(e.z))));
    s = (m_slot[v] >= 10) ? 0 : m_slot[v];
    m_win_dx[v][s] = sat32(sx - m_prev_sx[v]);
    m_win_dy[v][s] = sat32(sy - m_prev_sy[v]);
    m_prev_sx[v] = sx;
    m_prev_sy[v] = sy;
    sumx = 0;
    sumy = 0;
    for (int k = 0; k < 10; k++) begin
      sumx += m_win_dx[v][k];
      sumy += m_win_dy[v][k];
    end
    cnt = m_full[v] ? 10 : s + 1;
    avgx = sumx / cnt;   // truncates toward zero
    avgy = sumy / cnt;
    s++;
    if (s >= 10) begin
      s = 0;
      m_full[v] = 1'b1;
    end
    m_slot[v] = s;
    cx = clip(half_up16(-(gain * sx) + kdt * avgx + longint'(e.pvx) * 65536),
              smvc_pkg::UNIT_Q);
    cy = clip(half_up16(gain * sy + kdt * avgy + longint'(e.pvy) * 65536),
              smvc_pkg::UNIT_Q);
    cz = clip(half_up16(-(gain * sz)), smvc_pkg::UNIT_Q);
    yaw = (m_goal_hdg - longint'(e.hdg)) / 2;
    if (cx != 0 && cy != 0) begin
      // fold heading into (-pi/2, pi/2], then rotate by its negative
      th = longint'(e.hdg);
      while (th > smvc_pkg::HALF_PI_Q) th -= smvc_pkg::PI_Q;
      while (th <= -smvc_pkg::HALF_PI_Q) th += smvc_pkg::PI_Q;
      rx = cx * 16384;
      ry = cy * 16384;
      rz = -th * 16384;
      for (int i = 0; i < smvc_pkg::CORDIC_STEPS; i++) begin
        dx = ry >>> i;
        dy = rx >>> i;
        if (rz >= 0) begin
          rx -= dx; ry += dy; rz -= ATAN_Q30[i];
        end else begin
          rx += dx; ry -= dy; rz += ATAN_Q30[i];
        end
      end
      cx = clip((rx * smvc_pkg::CORDIC_K + (64'sd1 <<< 43)) >>> 44, smvc_pkg::ROT_LIMIT);
      cy = clip((ry * smvc_pkg::CORDIC_K + (64'sd1 <<< 43)) >>> 44, smvc_pkg::ROT_LIMIT);
    end
    c.veh = e.veh;
    c.vx  = cx[17:0];
    c.vy  = cy[17:0];
    c.vz  = cz[17:0];
    c.yaw = yaw[18:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Estimate driver: pops the queue, idles in bursts, predicts on transfer
  // ---------------------------------------------------------------------------
  estimate_t on_wire;
  int send_gap = 0;

  always @(posedge clk) begin
    command_t c;
    estimate_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (compute_command(on_wire, c)) predicted_cmds.push_back(c);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (estimate_q.size() > 0 && !calm && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else if (estimate_q.size() > 0) begin
          nx = estimate_q.pop_front();
          on_wire = nx;
          vehicle     <= nx.veh;
          est_x       <= nx.x;
          est_y       <= nx.y;
          est_z       <= nx.z;
          est_vx      <= nx.vx;
          est_vy      <= nx.vy;
          est_vz      <= nx.vz;
          est_heading <= nx.hdg;
          path_vx     <= nx.pvx;
          path_vy     <= nx.pvy;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command monitor: random stall bursts, one long hold-off, field checks
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    command_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_cmds.size() == 0) begin
          $error("command transfer for vehicle %0d with nothing predicted", out_vehicle);
          errors++;
        end else begin
          w = predicted_cmds.pop_front();
          if (out_vehicle !== w.veh) begin
            $error("out_vehicle: expected %0d, got %0d", w.veh, out_vehicle);
            errors++;
          end
          if (cmd_vx !== w.vx) begin
            $error("cmd_vx: expected %0d, got %0d", w.vx, cmd_vx);
            errors++;
          end
          if (cmd_vy !== w.vy) begin
            $error("cmd_vy: expected %0d, got %0d", w.vy, cmd_vy);
            errors++;
          end
          if (cmd_vz !== w.vz) begin
            $error("cmd_vz: expected %0d, got %0d", w.vz, cmd_vz);
            errors++;
          end
          if (cmd_yaw_rate !== w.yaw) begin
            $error("cmd_yaw_rate: expected %0d, got %0d", w.yaw, cmd_yaw_rate);
            errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: any transfer on any channel resets the count
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= DOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] near(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [18:0] any_heading();
    return ($urandom_range(0, 7) == 0) ? 19'($urandom)
                                       : 19'($signed($urandom_range(0, 411774)) - 205887);
  endfunction

  function automatic estimate_t rand_estimate();
    estimate_t e;
    int mode;
    mode = $urandom_range(0, 11);
    e.veh = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    e.hdg = any_heading();
    if (mode == 0) begin
      // raw noise across every bit
      e.x = $urandom; e.y = $urandom; e.z = $urandom;
      e.vx = $urandom; e.vy = $urandom; e.vz = $urandom;
      e.pvx = $urandom; e.pvy = $urandom;
    end else begin
      e.x = near(200000); e.y = near(200000); e.z = near(200000);
      e.vx = near(100000); e.vy = near(100000); e.vz = near(100000);
      e.pvx = near(40000); e.pvy = near(40000);
      if (mode == 1) begin
        // first-fix test: silent unless already active
        e.x = '0;
        e.y = '0;
      end
    end
    return e;
  endfunction

  function automatic estimate_t make_est(input logic [5:0] v, input logic signed [31:0] x,
                                         input logic signed [31:0] y, input logic signed [31:0] w,
                                         input logic signed [18:0] h);
    estimate_t e;
    e.veh = v; e.x = x; e.y = y; e.z = w;
    e.vx = w; e.vy = w; e.vz = w;
    e.hdg = h; e.pvx = w; e.pvy = w;
    return e;
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // let everything in flight land, incl. items that produce no command
  task automatic drain();
    do @(posedge clk); while (estimate_q.size() > 0 || in_valid || predicted_cmds.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) estimate_q.push_back(rand_estimate());
  endtask

  initial begin
    logic signed [31:0] lo, hi;
    lo = 32'sh8000_0000;
    hi = 32'sh7fff_ffff;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset defaults: silent vehicles, extremes, heading folds, window wrap
    estimate_q.push_back(make_est(6'd5, 0, 0, 1000, 0));          // stays silent
    estimate_q.push_back(make_est(6'd5, 0, 1, 0, 0));             // y alone activates
    estimate_q.push_back(make_est(6'd5, 0, 0, 0, 0));             // active now, zeros
    estimate_q.push_back(make_est(6'd63, hi, hi, hi, 19'sd205887));
    estimate_q.push_back(make_est(6'd62, lo, lo, lo, -19'sd205887));
    estimate_q.push_back(make_est(6'd61, hi, lo, lo, 19'sh3ffff));  // raw max pattern
    estimate_q.push_back(make_est(6'd60, lo, hi, hi, 19'sh40000));  // raw min pattern
    estimate_q.push_back(make_est(6'd2, 30000, -20000, 5000, 19'sd102944));
    estimate_q.push_back(make_est(6'd2, 30000, -20000, 5000, -19'sd102944));
    estimate_q.push_back(make_est(6'd2, 30000, -20000, 5000, 19'sd102945));
    for (int i = 0; i < 12; i++)
      estimate_q.push_back(make_est(6'd1, near(80000), near(80000), near(30000), any_heading()));
    drain();

    // every register, odd values; high byte of slope data must be dropped
    set_reg(smvc_pkg::REG_SLOPE, {8'hA5, 24'd40000});
    set_reg(smvc_pkg::REG_GAIN, 32'd30000);
    set_reg(smvc_pkg::REG_DERIV, 32'd20000);
    set_reg(smvc_pkg::REG_GOAL_X, 32'd65536);
    set_reg(smvc_pkg::REG_GOAL_Y, -32'sd131072);
    set_reg(smvc_pkg::REG_GOAL_Z, 32'd32768);
    set_reg(smvc_pkg::REG_GOAL_HEADING, 32'd51000);
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    hold_req = 1'b1;      // backs the block up while the sender keeps offering
    queue_random(150);
    drain();              // sender waits for every command here

    // extremes
    set_reg(smvc_pkg::REG_SLOPE, 32'h00FF_FFFF);
    set_reg(smvc_pkg::REG_GAIN, 32'd0);
    set_reg(smvc_pkg::REG_DERIV, 32'h00FF_FFFF);
    set_reg(smvc_pkg::REG_GOAL_X, hi);
    set_reg(smvc_pkg::REG_GOAL_Y, lo);
    set_reg(smvc_pkg::REG_GOAL_Z, lo);
    set_reg(smvc_pkg::REG_GOAL_HEADING, 32'd205887);
    queue_random(110);
    drain();

    set_reg(smvc_pkg::REG_SLOPE, 32'd0);
    set_reg(smvc_pkg::REG_GAIN, 32'h00FF_FFFF);
    set_reg(smvc_pkg::REG_DERIV, 32'd0);
    set_reg(smvc_pkg::REG_GOAL_X, 32'd0);
    set_reg(smvc_pkg::REG_GOAL_Y, 32'd0);
    set_reg(smvc_pkg::REG_GOAL_Z, hi);
    set_reg(smvc_pkg::REG_GOAL_HEADING, -32'sd205887);
    queue_random(110);
    drain();

    // random mid settings, then a tail with no idling
    set_reg(smvc_pkg::REG_SLOPE, $urandom_range(0, 200000));
    set_reg(smvc_pkg::REG_GAIN, $urandom_range(0, 200000));
    set_reg(smvc_pkg::REG_DERIV, $urandom_range(0, 300000));
    set_reg(smvc_pkg::REG_GOAL_X, near(150000));
    set_reg(smvc_pkg::REG_GOAL_Y, near(150000));
    set_reg(smvc_pkg::REG_GOAL_Z, near(150000));
    set_reg(smvc_pkg::REG_GOAL_HEADING, 32'($signed(any_heading())));
    queue_random(80);
    while (estimate_q.size() > 20) @(posedge clk);
    calm = 1'b1;
    queue_random(60);
    drain();

    if (errors == 0 && predicted_cmds.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/smvc_pkg.sv
rtl/core/smvc_ctrl.sv
rtl/core/smvc_dp.sv
rtl/core/sliding_mode_velocity_controller.sv
bench/sliding_mode_velocity_controller_tb.sv
